@@ rtl/core/lrc_pkg.sv @@
`default_nettype none

package lrc_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_ENTRIES    = 64;
  localparam int unsigned DEF_COUNT_BITS = 16;

  // Capacity limit register
  localparam int unsigned CAP_W     = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd50;

  // Stream widths, padded to whole bytes
  localparam int unsigned IN_W  = 200;
  localparam int unsigned OUT_W = 136;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_GET    = 2'd1,
    CMD_EXISTS = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  // Payload of one cache entry
  typedef struct packed {
    logic [63:0] key;
    logic [63:0] name_hash;
    logic [31:0] size;
    logic [31:0] offset;
  } entry_t;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic compare;  // register key match
    logic apply;    // take the next rank order
    logic clear;    // drop all entries
    logic shift_r;  // insert without removal: cells after the slot move right
    logic remove;   // one entry leaves, new one goes in: cells in between move left
  } ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/lrc_cell.sv @@
`default_nettype none

// One rank position of the cache. Cells sit in rank order, lowest count first.
module lrc_cell #(
  parameter int unsigned CountBits = lrc_pkg::DEF_COUNT_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire lrc_pkg::ctrl_t        ctrl_i,
  input  wire logic [63:0]           key_i,
  input  wire lrc_pkg::entry_t       new_ent_i,
  input  wire logic [CountBits-1:0]  new_cnt_i,
  input  wire logic                  rm_i,
  input  wire logic                  after_i,
  input  wire logic                  left_valid_i,
  input  wire lrc_pkg::entry_t       left_ent_i,
  input  wire logic [CountBits-1:0]  left_cnt_i,
  input  wire logic                  left_le_i,
  input  wire logic                  right_valid_i,
  input  wire lrc_pkg::entry_t       right_ent_i,
  input  wire logic [CountBits-1:0]  right_cnt_i,
  input  wire logic                  right_le_i,
  output logic                       valid_o,
  output lrc_pkg::entry_t            ent_o,
  output logic [CountBits-1:0]       cnt_o,
  output logic                       le_o,
  output logic                       match_o
);

  logic                 valid_q, valid_d;
  logic                 match_q;
  lrc_pkg::entry_t      ent_q, ent_d;
  logic [CountBits-1:0] cnt_q, cnt_d;
  logic                 le_w;

  // stays ahead of the placed entry
  assign le_w = valid_q && (cnt_q <= new_cnt_i) && !rm_i;

  // local reorder decision
  always_comb begin
    valid_d = valid_q;
    ent_d   = ent_q;
    cnt_d   = cnt_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.apply && ctrl_i.shift_r) begin
      if (!le_w) begin
        if (left_le_i) begin
          valid_d = 1'b1;
          ent_d   = new_ent_i;
          cnt_d   = new_cnt_i;
        end else begin
          valid_d = left_valid_i;
          ent_d   = left_ent_i;
          cnt_d   = left_cnt_i;
        end
      end
    end else if (ctrl_i.apply && ctrl_i.remove && after_i) begin
      if (right_le_i) begin
        valid_d = right_valid_i;
        ent_d   = right_ent_i;
        cnt_d   = right_cnt_i;
      end else if (rm_i || le_w) begin
        valid_d = 1'b1;
        ent_d   = new_ent_i;
        cnt_d   = new_cnt_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (ctrl_i.compare) begin
        match_q <= valid_q && (ent_q.key == key_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    cnt_q <= cnt_d;
  end

  assign valid_o = valid_q;
  assign ent_o   = ent_q;
  assign cnt_o   = cnt_q;
  assign le_o    = le_w;
  assign match_o = match_q;

endmodule

`default_nettype wire

@@ rtl/core/lfu_record_cache.sv @@
// LFU record cache, keyed by a 64-bit hash.
// Requests arrive on s_axis_*: tdata carries command, lookup key and the
// record to insert. One result per request leaves on m_axis_*, in order.
// The capacity limit is to be written through cfg_we_i / cfg_wdata_i only
// while idle; that binds the user, the block itself leaves it unchecked.
// Entries live in a chain of cells kept in rank order (lowest use count
// first); each request is a key compare in every cell, a select of the
// matching cell (wide OR and AND-OR of the cells), then one local shift
// step in which every cell takes its own, its left or its right neighbor's
// entry, or the placed entry. The result is registered in the output
// register after apply; one request is in flight at a time, so a new
// request is taken only once the last has passed the apply step.
// Reset empties the cache and sets the limit to 50.
// When the receiver stalls, the result waits in the output register; the
// next request is still taken and held at the apply step until the output
// register is free.
`default_nettype none

module lfu_record_cache #(
  parameter int unsigned Entries   = lrc_pkg::DEF_ENTRIES,
  parameter int unsigned CountBits = lrc_pkg::DEF_COUNT_BITS
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [lrc_pkg::CAP_W-1:0] cfg_wdata_i,   // capacity_limit
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // command[1:0], lookup_key[65:2], record_name_hash[129:66],
  // record_size[161:130], record_offset[193:162]
  input  wire logic [lrc_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // hit[0], inserted[1], out_name_hash[65:2], out_size[97:66],
  // out_offset[129:98]
  output logic [lrc_pkg::OUT_W-1:0]      m_axis_tdata
);

  localparam int unsigned LiveW = $clog2(Entries + 1);
  localparam int unsigned CmpW  = ((LiveW > lrc_pkg::CAP_W) ? LiveW : lrc_pkg::CAP_W) + 1;
  localparam int unsigned ResW  = 130;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MATCH = 4'b0010,
    ST_SEL   = 4'b0100,
    ST_APPLY = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // capacity register
  logic [lrc_pkg::CAP_W-1:0] cap_q;

  // request registers
  lrc_pkg::cmd_e   req_cmd_q;
  lrc_pkg::entry_t req_ent_q;

  // apply registers
  logic                 do_ins_q, do_rem_q, do_clr_q;
  lrc_pkg::entry_t      new_ent_q;
  logic [CountBits-1:0] new_cnt_q;
  logic [Entries-1:0]   rm_q, after_q;
  logic [ResW-1:0]      res_q;
  logic [LiveW-1:0]     live_q;

  // output register
  logic            m_valid_q;
  logic [ResW-1:0] m_data_q;

  // cell chain wires
  logic                 cell_valid [Entries];
  lrc_pkg::entry_t      cell_ent   [Entries];
  logic [CountBits-1:0] cell_cnt   [Entries];
  logic                 cell_le    [Entries];
  logic [Entries-1:0]   match_v;
  lrc_pkg::ctrl_t       ctrl;

  logic s_fire, out_free, a_fire;

  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign a_fire   = (state_q == ST_APPLY) && out_free;

  assign s_axis_tready = (state_q == ST_IDLE);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (s_fire) state_d = ST_MATCH;
      ST_MATCH: state_d = ST_SEL;
      ST_SEL:   state_d = ST_APPLY;
      ST_APPLY: if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // broadcast control
  always_comb begin
    ctrl.compare = (state_q == ST_MATCH);
    ctrl.apply   = a_fire && (do_ins_q || do_rem_q);
    ctrl.clear   = a_fire && do_clr_q;
    ctrl.shift_r = do_ins_q;
    ctrl.remove  = do_rem_q;
  end

  // hit, matching entry and rank positions at or after it
  logic                 hit_w;
  lrc_pkg::entry_t      sel_ent;
  logic [CountBits-1:0] sel_cnt, inc_cnt;
  logic [Entries-1:0]   after_v;
  always_comb begin
    hit_w   = |match_v;
    sel_ent = '0;
    sel_cnt = '0;
    for (int j = 0; j < Entries; j++) begin
      sel_ent = sel_ent | (match_v[j] ? cell_ent[j] : '0);
      sel_cnt = sel_cnt | (match_v[j] ? cell_cnt[j] : '0);
      after_v[j] = |(match_v & ({Entries{1'b1}} >> (Entries - 1 - j)));
    end
    inc_cnt = (sel_cnt == {CountBits{1'b1}}) ? sel_cnt : sel_cnt + CountBits'(1);
  end

  // eviction check against the clamped limit
  logic [CmpW-1:0] cap_ext, lim, live_inc;
  logic            evict;
  always_comb begin
    cap_ext  = CmpW'(cap_q);
    live_inc = CmpW'(live_q) + CmpW'(1);
    if (cap_ext < CmpW'(2)) begin
      lim = CmpW'(2);
    end else if (cap_ext > CmpW'(Entries)) begin
      lim = CmpW'(Entries);
    end else begin
      lim = cap_ext;
    end
    evict = (live_inc >= lim) && (live_q != '0);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cap_q     <= lrc_pkg::CAP_RESET;
      do_ins_q  <= 1'b0;
      do_rem_q  <= 1'b0;
      do_clr_q  <= 1'b0;
      live_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (state_q == ST_SEL) begin
        do_ins_q <= (req_cmd_q == lrc_pkg::CMD_INSERT) && !hit_w && !evict;
        do_rem_q <= ((req_cmd_q == lrc_pkg::CMD_INSERT) && !hit_w && evict) ||
                    ((req_cmd_q == lrc_pkg::CMD_GET) && hit_w);
        do_clr_q <= (req_cmd_q == lrc_pkg::CMD_CLEAR);
      end
      if (a_fire) begin
        if (do_clr_q) begin
          live_q <= '0;
        end else if (do_ins_q) begin
          live_q <= live_q + LiveW'(1);
        end
      end
      if (a_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      req_cmd_q           <= lrc_pkg::cmd_e'(s_axis_tdata[1:0]);
      req_ent_q.key       <= s_axis_tdata[65:2];
      req_ent_q.name_hash <= s_axis_tdata[129:66];
      req_ent_q.size      <= s_axis_tdata[161:130];
      req_ent_q.offset    <= s_axis_tdata[193:162];
    end
  end

  // select stage: plan of the apply step and the result
  lrc_pkg::entry_t      new_ent_d;
  logic [CountBits-1:0] new_cnt_d;
  logic [Entries-1:0]   rm_d, after_d;
  logic [ResW-1:0]      res_d;
  always_comb begin
    new_ent_d = req_ent_q;
    new_cnt_d = CountBits'(1);
    rm_d      = '0;
    after_d   = '0;
    res_d     = '0;
    case (req_cmd_q)
      lrc_pkg::CMD_INSERT: begin
        if (!hit_w) begin
          res_d[1] = 1'b1;
          if (evict) begin
            rm_d    = Entries'(1);
            after_d = '1;
          end
        end
      end
      lrc_pkg::CMD_GET: begin
        if (hit_w) begin
          new_ent_d = sel_ent;
          new_cnt_d = inc_cnt;
          rm_d      = match_v;
          after_d   = after_v;
          res_d     = {sel_ent.offset, sel_ent.size, sel_ent.name_hash, 1'b0, 1'b1};
        end
      end
      lrc_pkg::CMD_EXISTS: begin
        res_d[0] = hit_w;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SEL) begin
      new_ent_q <= new_ent_d;
      new_cnt_q <= new_cnt_d;
      rm_q      <= rm_d;
      after_q   <= after_d;
      res_q     <= res_d;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      m_data_q <= res_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(lrc_pkg::OUT_W - ResW)'(0), m_data_q};

  // chain of rank cells
  for (genvar j = 0; j < Entries; j++) begin : g_cell
    logic                 l_valid, r_valid, l_le, r_le;
    lrc_pkg::entry_t      l_ent, r_ent;
    logic [CountBits-1:0] l_cnt, r_cnt;

    if (j == 0) begin : g_head
      assign l_valid = 1'b0;
      assign l_ent   = '0;
      assign l_cnt   = '0;
      assign l_le    = 1'b1;
    end else begin : g_mid_l
      assign l_valid = cell_valid[j-1];
      assign l_ent   = cell_ent[j-1];
      assign l_cnt   = cell_cnt[j-1];
      assign l_le    = cell_le[j-1];
    end

    if (j == Entries - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_ent   = '0;
      assign r_cnt   = '0;
      assign r_le    = 1'b0;
    end else begin : g_mid_r
      assign r_valid = cell_valid[j+1];
      assign r_ent   = cell_ent[j+1];
      assign r_cnt   = cell_cnt[j+1];
      assign r_le    = cell_le[j+1];
    end

    lrc_cell #(
      .CountBits (CountBits)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .key_i         (req_ent_q.key),
      .new_ent_i     (new_ent_q),
      .new_cnt_i     (new_cnt_q),
      .rm_i          (rm_q[j]),
      .after_i       (after_q[j]),
      .left_valid_i  (l_valid),
      .left_ent_i    (l_ent),
      .left_cnt_i    (l_cnt),
      .left_le_i     (l_le),
      .right_valid_i (r_valid),
      .right_ent_i   (r_ent),
      .right_cnt_i   (r_cnt),
      .right_le_i    (r_le),
      .valid_o       (cell_valid[j]),
      .ent_o         (cell_ent[j]),
      .cnt_o         (cell_cnt[j]),
      .le_o          (cell_le[j]),
      .match_o       (match_v[j])
    );
  end

endmodule

`default_nettype wire

@@ verif/lfu_record_cache_test.sv @@
module lfu_record_cache_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRIES      = lrc_pkg::DEF_ENTRIES;
  localparam int unsigned COUNT_MAX    = (1 << lrc_pkg::DEF_COUNT_BITS) - 1;
  localparam int unsigned CYCLE_LIMIT  = 100_000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LONG_HOLD    = 200;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned POOL_MAX     = 72;

  localparam logic [63:0] ALL1  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] PAT_A = {16{4'hA}};
  localparam logic [63:0] PAT_5 = {16{4'h5}};

  // Request as packed on s_axis_tdata, command in the low bits
  typedef struct packed {
    logic [5:0]    pad;
    logic [31:0]   offset;
    logic [31:0]   size;
    logic [63:0]   name_hash;
    logic [63:0]   key;
    lrc_pkg::cmd_e command;
  } request_t;

  // Response as packed on m_axis_tdata, hit in bit 0
  typedef struct packed {
    logic [5:0]  pad;
    logic [31:0] offset;
    logic [31:0] size;
    logic [63:0] name_hash;
    logic        inserted;
    logic        hit;
  } response_t;

  typedef struct {
    request_t  req;
    bit        typed;
    response_t resp;
  } case_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [lrc_pkg::CAP_W-1:0] cfg_wdata_i;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [lrc_pkg::IN_W-1:0]  s_axis_tdata;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [lrc_pkg::OUT_W-1:0] m_axis_tdata;

  // Cache contents as the block should hold them
  logic                      live      [ENTRIES];
  logic [63:0]               key_of    [ENTRIES];
  logic [63:0]               hash_of   [ENTRIES];
  logic [31:0]               size_of   [ENTRIES];
  logic [31:0]               offset_of [ENTRIES];
  logic [15:0]               uses_of   [ENTRIES];
  int                        rank_q[$];        // live slots, next victim first
  logic [lrc_pkg::CAP_W-1:0] limit_setting;

  response_t         responses_due[$];
  case_row_t         directed_rows[$];
  logic [63:0]       key_pool [POOL_MAX];
  int unsigned       fault_count = 0;
  int unsigned       cycle_count = 0;
  int unsigned       burst_left  = 0;
  bit                free_flow    = 1'b0;
  bit                hold_pending = 1'b0;

  logic [lrc_pkg::CAP_W-1:0] phase_limit [PHASES] =
    '{7'd2, 7'd0, 7'd1, 7'd3, 7'd7, 7'd64, 7'd127, 7'd20};
  int unsigned       phase_items [PHASES] = '{40, 40, 30, 60, 70, 160, 160, 70};

  lfu_record_cache DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Limits below 2 act as 2, above the slot count as the slot count
  function automatic int unsigned clamp_limit(input logic [lrc_pkg::CAP_W-1:0] v);
    if (v < 2) return 2;
    if (v > ENTRIES) return ENTRIES;
    return 32'(v);
  endfunction

  function automatic int find_live(input logic [63:0] k);
    for (int i = 0; i < ENTRIES; i++)
      if (live[i] && key_of[i] == k) return i;
    return -1;
  endfunction

  // Rank a slot after every entry with a use count at or below its own
  function automatic void rank_in(input int slot);
    int pos;
    pos = 0;
    while (pos < rank_q.size() && uses_of[rank_q[pos]] <= uses_of[slot]) pos++;
    rank_q.insert(pos, slot);
  endfunction

  // Apply one request to the cache state and return its response
  function automatic response_t lfu_apply(input request_t r);
    response_t o;
    int        slot;
    o = '0;
    slot = find_live(r.key);
    case (r.command)
      lrc_pkg::CMD_INSERT: begin
        if (slot < 0) begin
          if (rank_q.size() + 1 >= clamp_limit(limit_setting) && rank_q.size() > 0) begin
            live[rank_q[0]] = 1'b0;
            rank_q.delete(0);
          end
          slot = 0;
          while (slot < ENTRIES && live[slot]) slot++;
          if (slot < ENTRIES) begin
            live[slot]      = 1'b1;
            key_of[slot]    = r.key;
            hash_of[slot]   = r.name_hash;
            size_of[slot]   = r.size;
            offset_of[slot] = r.offset;
            uses_of[slot]   = 16'd1;
            rank_in(slot);
            o.inserted = 1'b1;
          end
        end
      end
      lrc_pkg::CMD_GET: begin
        if (slot >= 0) begin
          o.hit       = 1'b1;
          o.name_hash = hash_of[slot];
          o.size      = size_of[slot];
          o.offset    = offset_of[slot];
          for (int i = 0; i < rank_q.size(); i++)
            if (rank_q[i] == slot) begin
              rank_q.delete(i);
              break;
            end
          if (uses_of[slot] != COUNT_MAX) uses_of[slot] = uses_of[slot] + 16'd1;
          rank_in(slot);
        end
      end
      lrc_pkg::CMD_EXISTS: o.hit = (slot >= 0);
      default: begin
        foreach (live[i]) live[i] = 1'b0;
        rank_q.delete();
      end
    endcase
    return o;
  endfunction

  function automatic request_t req_of(input lrc_pkg::cmd_e c, input logic [63:0] k,
                                      input logic [63:0] nh, input logic [31:0] sz,
                                      input logic [31:0] off);
    request_t r;
    r = '0;
    r.command   = c;
    r.key       = k;
    r.name_hash = nh;
    r.size      = sz;
    r.offset    = off;
    return r;
  endfunction

  function automatic response_t resp_of(input logic h, input logic ins,
                                        input logic [63:0] nh, input logic [31:0] sz,
                                        input logic [31:0] off);
    response_t p;
    p = '0;
    p.hit       = h;
    p.inserted  = ins;
    p.name_hash = nh;
    p.size      = sz;
    p.offset    = off;
    return p;
  endfunction

  task automatic add_row(input request_t q, input bit typed, input response_t p);
    case_row_t row;
    row.req   = q;
    row.typed = typed;
    row.resp  = p;
    directed_rows.push_back(row);
  endtask

  // Mostly keys from the phase pool so gets and re-inserts hit
  function automatic request_t random_request(input int pool_n, input int clear_pct);
    request_t    r;
    int unsigned pick;
    r = '0;
    pick = $urandom_range(99);
    if (pick < clear_pct) r.command = lrc_pkg::CMD_CLEAR;
    else if (pick < 50) r.command = lrc_pkg::CMD_INSERT;
    else if (pick < 82) r.command = lrc_pkg::CMD_GET;
    else r.command = lrc_pkg::CMD_EXISTS;
    r.key       = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                           : key_pool[$urandom_range(pool_n - 1)];
    r.name_hash = {$urandom, $urandom};
    r.size      = $urandom;
    r.offset    = $urandom;
    return r;
  endfunction

  // Offer one request, predict on accept, then maybe idle between bursts
  task automatic issue(input request_t r, input bit typed, input response_t typed_resp);
    response_t   due;
    int unsigned gap;
    s_axis_tdata  <= r;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    due = lfu_apply(r);
    responses_due.push_back(typed ? typed_resp : due);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && !free_flow) begin
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
      gap = $urandom_range(6, 1);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Register write only once the block has gone quiet
  task automatic write_limit(input logic [lrc_pkg::CAP_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (responses_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    limit_setting = v;
    cfg_we_i <= 1'b0;
  endtask

  task automatic check_response(input response_t got);
    response_t want;
    if (responses_due.size() == 0) begin
      fault_count++;
      if (fault_count <= 10) $display("response with no request outstanding: %h", got);
    end else begin
      want = responses_due.pop_front();
      if (got.hit !== want.hit || got.inserted !== want.inserted ||
          got.name_hash !== want.name_hash || got.size !== want.size ||
          got.offset !== want.offset) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("mismatch want: hit=%b ins=%b hash=%h size=%h off=%h",
                   want.hit, want.inserted, want.name_hash, want.size, want.offset);
          $display("         got:  hit=%b ins=%b hash=%h size=%h off=%h",
                   got.hit, got.inserted, got.name_hash, got.size, got.offset);
        end
      end
    end
  endtask

  // Response monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_response(m_axis_tdata);
  end

  // Receiver: random stalls, long hold-off on request, always ready in free flow
  initial begin : response_sink
    m_axis_tready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (free_flow || $urandom_range(3) == 0) begin
        m_axis_tready <= 1'b1;
        repeat (free_flow ? 1 : $urandom_range(30, 8)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(5, 1)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(3, 1)) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    logic [lrc_pkg::CAP_W-1:0] lim;
    int unsigned               eff;
    int                        pool_n;
    logic [63:0]               tie_a;
    logic [63:0]               tie_b;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    foreach (live[i]) live[i] = 1'b0;
    limit_setting = lrc_pkg::CAP_RESET;

    // Directed: empty cache, field extremes, duplicate insert, clear
    add_row(req_of(lrc_pkg::CMD_GET, 64'd0, ALL1, '1, '1), 1'b1,
            resp_of(1'b0, 1'b0, '0, '0, '0));
    add_row(req_of(lrc_pkg::CMD_EXISTS, ALL1, '0, '0, '0), 1'b1,
            resp_of(1'b0, 1'b0, '0, '0, '0));
    add_row(req_of(lrc_pkg::CMD_INSERT, 64'd0, '0, '0, '0), 1'b1,
            resp_of(1'b0, 1'b1, '0, '0, '0));
    add_row(req_of(lrc_pkg::CMD_INSERT, ALL1, ALL1, '1, '1), 1'b1,
            resp_of(1'b0, 1'b1, '0, '0, '0));
    add_row(req_of(lrc_pkg::CMD_INSERT, 64'd0, PAT_A, '1, '1), 1'b1,
            resp_of(1'b0, 1'b0, '0, '0, '0));
    add_row(req_of(lrc_pkg::CMD_GET, 64'd0, '0, '0, '0), 1'b1,
            resp_of(1'b1, 1'b0, '0, '0, '0));
    add_row(req_of(lrc_pkg::CMD_GET, ALL1, '0, '0, '0), 1'b1,
            resp_of(1'b1, 1'b0, ALL1, '1, '1));
    add_row(req_of(lrc_pkg::CMD_EXISTS, 64'd0, '0, '0, '0), 1'b1,
            resp_of(1'b1, 1'b0, '0, '0, '0));
    add_row(req_of(lrc_pkg::CMD_EXISTS, 64'd1, '0, '0, '0), 1'b1,
            resp_of(1'b0, 1'b0, '0, '0, '0));
    add_row(req_of(lrc_pkg::CMD_INSERT, PAT_A, PAT_5, 32'hAAAA_AAAA, 32'h5555_5555), 1'b1,
            resp_of(1'b0, 1'b1, '0, '0, '0));
    add_row(req_of(lrc_pkg::CMD_GET, PAT_A, '0, '0, '0), 1'b1,
            resp_of(1'b1, 1'b0, PAT_5, 32'hAAAA_AAAA, 32'h5555_5555));
    add_row(req_of(lrc_pkg::CMD_INSERT, PAT_5, PAT_A, 32'h5555_5555, 32'hAAAA_AAAA), 1'b1,
            resp_of(1'b0, 1'b1, '0, '0, '0));
    add_row(req_of(lrc_pkg::CMD_GET, PAT_5, '0, '0, '0), 1'b1,
            resp_of(1'b1, 1'b0, PAT_A, 32'h5555_5555, 32'hAAAA_AAAA));
    add_row(req_of(lrc_pkg::CMD_EXISTS, PAT_A, '0, '0, '0), 1'b1,
            resp_of(1'b1, 1'b0, '0, '0, '0));
    add_row(req_of(lrc_pkg::CMD_CLEAR, ALL1, ALL1, '1, '1), 1'b1,
            resp_of(1'b0, 1'b0, '0, '0, '0));
    add_row(req_of(lrc_pkg::CMD_EXISTS, 64'd0, '0, '0, '0), 1'b1,
            resp_of(1'b0, 1'b0, '0, '0, '0));
    add_row(req_of(lrc_pkg::CMD_GET, ALL1, '0, '0, '0), 1'b1,
            resp_of(1'b0, 1'b0, '0, '0, '0));
    add_row(req_of(lrc_pkg::CMD_INSERT, ALL1, {$urandom, $urandom}, $urandom, $urandom),
            1'b0, '0);
    add_row(req_of(lrc_pkg::CMD_GET, ALL1, '0, '0, '0), 1'b0, '0);
    add_row(req_of(lrc_pkg::CMD_EXISTS, PAT_5, '0, '0, '0), 1'b1,
            resp_of(1'b0, 1'b0, '0, '0, '0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].resp);

    // Random phases, one capacity limit each
    for (int p = 0; p < PHASES; p++) begin
      lim = (p == PHASES - 1) ? lrc_pkg::CAP_W'($urandom_range(60, 4)) : phase_limit[p];
      write_limit(lim);
      eff    = clamp_limit(lim);
      pool_n = eff + 3;
      for (int k = 0; k < pool_n; k++) key_pool[k] = {$urandom, $urandom};
      for (int n = 0; n < phase_items[p]; n++) begin
        // receiver backs off for a while so the block fills and stalls requests
        if (n == 30 && (p == 0 || p == 5)) hold_pending = 1'b1;
        issue(random_request(pool_n, (eff > 32) ? 1 : 5), 1'b0, '0);
      end
    end

    // Equal use counts on two entries, then evict with limit 3:
    // the entry that reached the count first goes
    write_limit(7'd3);
    free_flow = 1'b1;
    tie_a = {$urandom, $urandom};
    tie_b = ~tie_a;
    issue(req_of(lrc_pkg::CMD_CLEAR, '0, '0, '0, '0), 1'b0, '0);
    issue(req_of(lrc_pkg::CMD_INSERT, tie_a, {$urandom, $urandom}, $urandom, $urandom),
          1'b0, '0);
    issue(req_of(lrc_pkg::CMD_INSERT, tie_b, {$urandom, $urandom}, $urandom, $urandom),
          1'b0, '0);
    repeat (2) issue(req_of(lrc_pkg::CMD_GET, tie_a, '0, '0, '0), 1'b0, '0);
    repeat (2) issue(req_of(lrc_pkg::CMD_GET, tie_b, '0, '0, '0), 1'b0, '0);
    issue(req_of(lrc_pkg::CMD_INSERT, {tie_a[63:1], ~tie_a[0]}, {$urandom, $urandom},
                 $urandom, $urandom), 1'b0, '0);
    issue(req_of(lrc_pkg::CMD_EXISTS, tie_a, '0, '0, '0), 1'b0, '0);
    issue(req_of(lrc_pkg::CMD_EXISTS, tie_b, '0, '0, '0), 1'b0, '0);
    issue(req_of(lrc_pkg::CMD_GET, {tie_a[63:1], ~tie_a[0]}, '0, '0, '0), 1'b0, '0);
    free_flow = 1'b0;

    s_axis_tvalid <= 1'b0;
    while (responses_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fault_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

@@ lfu_record_cache.f @@
rtl/core/lrc_pkg.sv
rtl/core/lrc_cell.sv
rtl/core/lfu_record_cache.sv
verif/lfu_record_cache_test.sv
